// ===== rtl/ordered_list_store_top_macros.svh =====
// assertion macros for the ordered list store
`ifndef ORDERED_LIST_STORE_TOP_MACROS_SVH
`define ORDERED_LIST_STORE_TOP_MACROS_SVH

// same-cycle implication
`define OLST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list store check failed");

// next-cycle implication
`define OLST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list store check failed");

`endif

// ===== rtl/olst_pkg.sv =====
// package with command and status codes and the cell control struct
package olst_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // per-cell control: where the cell takes its next value from
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } olst_ctl_t;

endpackage

// ===== rtl/ordered_list_store_top.sv =====
// ordered list store: up to CAPACITY signed words in a shifting cell chain
// done: the result strobe rises in the cycle after a command is accepted
// throughput: one command per cycle; every cell shifts at once, so the
// whole list moves together and busy stays low
// reset: synchronous rst empties the list and clears done; cell contents
// are left as they are and never read before written
`include "ordered_list_store_top_macros.svh"

module ordered_list_store_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [olst_pkg::CMD_W-1:0]           cmd,
  input  logic signed [olst_pkg::DATA_W-1:0]   item,
  input  logic [olst_pkg::POS_W-1:0]           position,
  output logic                                 done,
  output logic [olst_pkg::STATUS_W-1:0]        status,
  output logic signed [olst_pkg::DATA_W-1:0]   removed_value
);
  import olst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = POS_W + 1;

  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  logic signed [DATA_W-1:0] vals [CAPACITY];
  olst_ctl_t ctl [CAPACITY];

  logic accept;
  logic ins_ok;
  logic del_ok;
  logic [IDX_W-1:0] p0;
  logic [STATUS_W-1:0] st;
  logic full;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] len_c;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign full = (length == LEN_W'(CAPACITY));
  assign pos_c = {1'b0, position};
  assign len_c = CMP_W'(length);

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    p0 = '0;
    st = ST_OK;
    unique case (cmd)
      CMD_INS_FRONT, CMD_INS_REAR: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          p0 = (cmd == CMD_INS_FRONT) ? '0 : IDX_W'(length);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_REAR: begin
        if (length == '0) begin
          st = ST_EMPTY;
        end else begin
          del_ok = 1'b1;
          p0 = (cmd == CMD_DEL_FRONT) ? '0 : IDX_W'(length - 1'b1);
        end
      end
      CMD_INS_POS: begin
        // bounds check wins over full
        if (position == '0 || pos_c > len_c + 1'b1) begin
          st = ST_BOUNDS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          p0 = IDX_W'(position - 1'b1);
        end
      end
      CMD_DEL_POS: begin
        if (length == '0) begin
          st = ST_EMPTY;
        end else if (position == '0 || pos_c > len_c) begin
          st = ST_BOUNDS;
        end else begin
          del_ok = 1'b1;
          p0 = IDX_W'(position - 1'b1);
        end
      end
      default: begin
        st = ST_BOUNDS;
      end
    endcase
  end

  always_comb begin
    length_next = length;
    if (accept && ins_ok) begin
      length_next = length + 1'b1;
    end else if (accept && del_ok) begin
      length_next = length - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done <= 1'b0;
    end else begin
      length <= length_next;
      done <= accept;
    end
  end

  // result word; the removed value is read before the chain shifts
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= st;
      removed_value <= del_ok ? vals[p0] : '0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    // ends of the chain feed back their own value
    if (i == 0) begin : g_first
      assign left_val = vals[i];
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    always_comb begin
      ctl[i].load = accept && ins_ok && (IDX_W'(i) == p0);
      ctl[i].from_left = accept && ins_ok && (IDX_W'(i) > p0);
      ctl[i].from_right = accept && del_ok && (IDX_W'(i) >= p0);
    end

    olst_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[i]),
      .item  (item),
      .left  (left_val),
      .right (right_val),
      .value (vals[i])
    );
  end

  `OLST_ASSERT_NEXT(a_done_follows, clk, rst, accept, done)
  `OLST_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, length <= LEN_W'(CAPACITY))
  `OLST_ASSERT_NOW(a_removed_ok, clk, rst, done && removed_value != '0, status == ST_OK)
  `OLST_ASSERT_NEXT(a_len_grows, clk, rst, accept && ins_ok, length == $past(length) + 1'b1)

endmodule

// ===== rtl/olst_cell.sv =====
// one storage cell of the shifting element chain
module olst_cell (
  input  logic                             clk,
  input  olst_pkg::olst_ctl_t              ctl,
  input  logic signed [olst_pkg::DATA_W-1:0] item,
  input  logic signed [olst_pkg::DATA_W-1:0] left,
  input  logic signed [olst_pkg::DATA_W-1:0] right,
  output logic signed [olst_pkg::DATA_W-1:0] value
);
  import olst_pkg::*;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      value <= item;
    end else if (ctl.from_left) begin
      value <= left;
    end else if (ctl.from_right) begin
      value <= right;
    end else begin
      value <= value;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the ordered list store
`timescale 1ns / 1ps

module tb_top;
  import olst_pkg::*;

  localparam int LIST_CAP = 16;
  // command codes the block does not define; both must answer out of bounds
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed;
  } list_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [CMD_W-1:0]           cmd = '0;
  logic signed [DATA_W-1:0]   item = '0;
  logic [POS_W-1:0]           position = '0;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   removed_value;

  // predicted list contents, front at index 0
  logic signed [DATA_W-1:0] shelf[$];
  list_result_t             result_q[$];
  list_result_t             pend_word;
  bit                       pend_valid = 1'b0;
  bit                       idle_on = 1'b0;
  int                       errors = 0;
  int                       words_sent = 0;
  int                       words_checked = 0;
  int                       status_seen[4] = '{0, 0, 0, 0};

  ordered_list_store_top #(.CAPACITY(LIST_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .item(item),
    .position(position),
    .done(done),
    .status(status),
    .removed_value(removed_value)
  );

  always #2 clk = ~clk;

  // apply one command to the predicted list and return its result
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                                  input logic signed [DATA_W-1:0] v,
                                                  input logic [POS_W-1:0] p);
    list_result_t r;
    int pi;
    r.status = ST_OK;
    r.removed = '0;
    pi = int'(p);
    case (c)
      CMD_INS_FRONT, CMD_INS_REAR: begin
        if (shelf.size() >= LIST_CAP) r.status = ST_FULL;
        else if (c == CMD_INS_FRONT) shelf.push_front(v);
        else shelf.push_back(v);
      end
      CMD_DEL_FRONT, CMD_DEL_REAR: begin
        if (shelf.size() == 0) r.status = ST_EMPTY;
        else if (c == CMD_DEL_FRONT) r.removed = shelf.pop_front();
        else r.removed = shelf.pop_back();
      end
      CMD_INS_POS: begin
        // position is checked before capacity
        if (pi < 1 || pi > shelf.size() + 1) r.status = ST_BOUNDS;
        else if (shelf.size() >= LIST_CAP) r.status = ST_FULL;
        else shelf.insert(pi - 1, v);
      end
      CMD_DEL_POS: begin
        if (shelf.size() == 0) r.status = ST_EMPTY;
        else if (pi < 1 || pi > shelf.size()) r.status = ST_BOUNDS;
        else begin
          r.removed = shelf[pi - 1];
          shelf.delete(pi - 1);
        end
      end
      default: r.status = ST_BOUNDS;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // send one word and record its prediction once it is taken
  task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                           input logic [POS_W-1:0] p);
    if (idle_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 13));
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    item <= v;
    position <= p;
    do @(posedge clk); while (busy);
    pend_word = apply_list_cmd(c, v, p);
    pend_valid = 1'b1;
    status_seen[pend_word.status]++;
    words_sent++;
  endtask

  // expectations join the queue on the falling edge after acceptance, clear of the check edge
  always @(negedge clk) begin
    if (pend_valid) begin
      result_q.push_back(pend_word);
      pend_valid = 1'b0;
    end
  end

  always @(posedge clk) begin
    list_result_t e;
    if (!rst && done) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d removed %0d", $time, status,
                 removed_value);
        errors++;
      end else begin
        e = result_q.pop_front();
        words_checked++;
        if (status !== e.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, status);
          errors++;
        end
        if (removed_value !== e.removed) begin
          $display("%0t: removed_value mismatch, expected %0d, got %0d", $time, e.removed,
                   removed_value);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_word(CMD_DEL_FRONT, pick_value(), POS_W'($urandom));
    send_word(CMD_DEL_REAR, pick_value(), POS_W'($urandom));
    send_word(CMD_DEL_POS, pick_value(), 7'd0);
    send_word(CMD_DEL_POS, pick_value(), 7'd127);
    send_word(CMD_INS_POS, pick_value(), 7'd0);
    send_word(CMD_INS_POS, pick_value(), 7'd2);
  endtask

  task automatic test_edge_values();
    send_word(CMD_INS_POS, 32'sh8000_0000, 7'd1);
    send_word(CMD_INS_FRONT, 32'sh7fff_ffff, 7'd0);
    send_word(CMD_INS_REAR, -32'sd1, 7'd127);
    send_word(CMD_INS_REAR, 32'sd0, 7'd0);
    send_word(CMD_DEL_POS, pick_value(), 7'd0);
    send_word(CMD_DEL_POS, pick_value(), 7'd5);
    send_word(CMD_DEL_POS, pick_value(), 7'd2);
    send_word(CMD_INS_POS, 32'sh5555_aaaa, 7'd4);
    send_word(CMD_RSVD_6, pick_value(), POS_W'($urandom));
    send_word(CMD_RSVD_7, pick_value(), POS_W'($urandom));
  endtask

  task automatic test_full_list();
    while (shelf.size() < LIST_CAP) send_word(CMD_INS_REAR, pick_value(), POS_W'($urandom));
    send_word(CMD_INS_FRONT, pick_value(), POS_W'($urandom));
    send_word(CMD_INS_REAR, pick_value(), POS_W'($urandom));
    send_word(CMD_INS_POS, pick_value(), 7'd1);
    send_word(CMD_INS_POS, pick_value(), 7'd127);
    send_word(CMD_INS_POS, pick_value(), POS_W'(LIST_CAP + 1));
    send_word(CMD_DEL_POS, pick_value(), POS_W'(LIST_CAP));
    send_word(CMD_DEL_POS, pick_value(), POS_W'(LIST_CAP));
    send_word(CMD_DEL_REAR, pick_value(), POS_W'($urandom));
    while (shelf.size() > 0) send_word(CMD_DEL_FRONT, pick_value(), POS_W'($urandom));
    send_word(CMD_DEL_REAR, pick_value(), POS_W'($urandom));
  endtask

  // random commands; the list is pushed toward full or toward empty, picked at random every 40 commands
  task automatic test_random_mix(input int n);
    int r;
    bit grow;
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;
    grow = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) grow = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 3) c = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
      else if (r < (grow ? 68 : 33)) begin
        case ($urandom_range(0, 2))
          0: c = CMD_INS_FRONT;
          1: c = CMD_INS_REAR;
          default: c = CMD_INS_POS;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: c = CMD_DEL_FRONT;
          1: c = CMD_DEL_REAR;
          default: c = CMD_DEL_POS;
        endcase
      end
      if ($urandom_range(0, 4) == 0) p = POS_W'($urandom);
      else p = POS_W'($urandom_range(0, shelf.size() + 2));
      send_word(c, pick_value(), p);
    end
  endtask

  initial begin
    int waited;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_mix(480);
    // closing stretch runs back to back
    idle_on = 1'b0;
    test_random_mix(150);
    idle_cycles(1);
    waited = 0;
    while ((result_q.size() != 0 || pend_valid) && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
      errors++;
    end
    $display("%0d commands sent, %0d results checked", words_sent, words_checked);
    $display("status mix: ok %0d, empty %0d, out of bounds %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BOUNDS],
             status_seen[ST_FULL]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
